// File: sv/rbm_pkg.sv
package rbm_pkg;

  localparam int unsigned ValW   = 40;
  localparam int unsigned BndW   = 41;
  localparam int unsigned EntW   = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned MinSize = 2;
  localparam int unsigned CapSize = 64;

  localparam logic [2:0] ActWrDist = 3'd0;
  localparam logic [2:0] ActWrFlow = 3'd1;
  localparam logic [2:0] ActWrCost = 3'd2;
  localparam logic [2:0] ActSort   = 3'd3;
  localparam logic [2:0] ActBound  = 3'd4;

  localparam logic RegSize = 1'b0;
  localparam logic RegKind = 1'b1;

  localparam logic [BndW-1:0] BndMax = {BndW{1'b1}};
  localparam logic [EntW-1:0] EntMax = {EntW{1'b1}};

  typedef struct packed {
    logic [2:0]      action;
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] col_index;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] location;
    logic [IdxW-1:0] facility;
    logic [BndW-1:0] bound;
    logic            last;
  } res_t;

  // controls from sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } mac_ctl_t;

  // saturating add of a product onto an accumulator
  function automatic logic [BndW-1:0] sat_add(logic [BndW-1:0] a, logic [2*EntW-1:0] p);
    logic [BndW:0] s;
    s = {1'b0, a} + {{(BndW + 1 - 2 * EntW){1'b0}}, p};
    sat_add = s[BndW] ? BndMax : s[BndW-1:0];
  endfunction

endpackage

// File: sv/rearrangement_bound_matrix_top.sv
// channel | dir | handshake           | payload
// req     | in  | req_valid_i/ready_o | req_i (req_t)
// res     | out | res_valid_o/ready_i | res_o (res_t)
// cfg     | in  | psel/penable/pready | paddr, pwdata, prdata
// a sort is an insertion sort (both matrices in turn); a bound row is built
// by the one shared multiply-accumulate unit after it is taken.
// reset is async active low; stores are not cleared.
// a stalled result holds the sequencer; no request is taken while busy.
module rearrangement_bound_matrix_top
  import rbm_pkg::*;
#(
  parameter int unsigned MAX_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RW = $clog2(MAX_SIZE);
  localparam int unsigned AW = 2 * RW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned EffMax = (MAX_SIZE < CapSize) ? MAX_SIZE : CapSize;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIAG  = 13'b0000000000010,
    S_DIAGW = 13'b0000000000100,
    S_KEY   = 13'b0000000001000,
    S_CMP   = 13'b0000000010000,
    S_MOVE  = 13'b0000000100000,
    S_PUT   = 13'b0000001000000,
    S_COST  = 13'b0000010000000,
    S_CLD   = 13'b0000100000000,
    S_MAC   = 13'b0001000000000,
    S_DRAIN = 13'b0010000000000,
    S_OUT   = 13'b0100000000000,
    S_DIAGR = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [SizeW-1:0] size_q;
  logic             kind_q;
  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(CapSize);
      kind_q <= 1'b1;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegSize) size_q <= pwdata[SizeW-1:0];
      else kind_q <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == RegKind) ? {31'd0, kind_q} : {25'd0, size_q};

  // effective size
  logic [8:0] n;
  always_comb begin
    if (size_q < SizeW'(MinSize)) n = 9'(MinSize);
    else if (9'(size_q) > 9'(EffMax)) n = 9'(EffMax);
    else n = 9'(size_q);
  end

  // stores
  logic [EntW-1:0] dist_mem [Depth];
  logic [EntW-1:0] flow_mem [Depth];
  logic [BndW-1:0] cost_mem [Depth];

  logic            sel_flow_q;
  logic [RW-1:0]   row_q, fac_q, loc_q;
  logic [8:0]      i_q, j_q, c_q;
  logic [EntW-1:0] key_q, dat_q;
  logic [EntW-1:0] rd_d_q, rd_f_q;
  logic [BndW-1:0] rd_c_q;
  logic [IdxW-1:0] res_loc_q, res_fac_q;
  logic [BndW-1:0] res_bnd_q;
  logic            res_last_q, res_valid_q;

  logic [AW-1:0]   rda_d, rda_f, wra;
  logic            we_d, we_f, we_c;
  logic [EntW-1:0] wdat;
  logic [BndW-1:0] wcost;
  logic [AW-1:0]   rda_c;
  logic [8:0]      kidx;
  logic [EntW-1:0] sat16;
  logic [BndW-1:0] acc;
  mac_ctl_t        ctl;
  logic            row_ok, ok_addr;

  assign ok_addr = (9'(req_i.row_index) < 9'(MAX_SIZE))
                   && (9'(req_i.col_index) < 9'(MAX_SIZE));
  assign sat16 = (req_i.value > ValW'(EntMax)) ? EntMax : req_i.value[EntW-1:0];
  assign row_ok = 9'(req_i.row_index) < n;
  assign kidx = kind_q ? (n - 9'd2 - c_q) : c_q;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (we_d) dist_mem[wra] <= wdat;
    if (we_f) flow_mem[wra] <= wdat;
    if (we_c) cost_mem[wra] <= wcost;
    rd_d_q <= dist_mem[rda_d];
    rd_f_q <= flow_mem[rda_f];
    rd_c_q <= cost_mem[rda_c];
  end

  logic [EntW-1:0] rd_s;
  assign rd_s = sel_flow_q ? rd_f_q : rd_d_q;

  rbm_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .init_i(rd_c_q),
    .a_i   (rd_d_q),
    .b_i   (rd_f_q),
    .acc_o (acc)
  );

  // sequencer control
  always_comb begin
    state_d = state_q;
    we_d = 1'b0; we_f = 1'b0; we_c = 1'b0;
    wra = '0; wdat = '0; wcost = acc;
    rda_d = '0; rda_f = '0; rda_c = {loc_q, fac_q};
    ctl = '0;
    unique case (state_q)
      S_IDLE: begin
        wra = {RW'(req_i.row_index), RW'(req_i.col_index)};
        wdat = sat16; wcost = {1'b0, req_i.value};
        if (req_valid_i && ok_addr) begin
          we_d = req_i.action == ActWrDist;
          we_f = req_i.action == ActWrFlow;
          we_c = req_i.action == ActWrCost;
        end
      end
      // last column read is held so it is still there at the write
      S_DIAG, S_DIAGR: begin
        rda_d = {row_q, RW'(n - 9'd1)}; rda_f = rda_d;
      end
      S_DIAGW: begin
        wra = {row_q, row_q}; wdat = rd_s;
        we_d = !sel_flow_q; we_f = sel_flow_q;
      end
      S_KEY: begin
        rda_d = {row_q, RW'(i_q)}; rda_f = rda_d;
      end
      S_CMP: begin
        rda_d = {row_q, RW'(j_q - 9'd1)}; rda_f = rda_d;
      end
      S_MOVE: begin
        wra = {row_q, RW'(j_q)}; wdat = rd_s;
        we_d = !sel_flow_q && rd_s > key_q; we_f = sel_flow_q && rd_s > key_q;
      end
      S_PUT: begin
        wra = {row_q, RW'(j_q)}; wdat = key_q;
        we_d = !sel_flow_q; we_f = sel_flow_q;
      end
      S_COST: ;
      S_CLD: begin
        ctl.load = 1'b1;
        rda_d = {loc_q, RW'(c_q)}; rda_f = {fac_q, RW'(kidx)};
      end
      S_MAC: begin
        rda_d = {loc_q, RW'(c_q)}; rda_f = {fac_q, RW'(kidx)};
        ctl.step = c_q > 9'd1;
      end
      S_DRAIN: ctl.step = 1'b1;
      S_OUT: begin
        wra = {loc_q, fac_q};
        we_c = !res_valid_q && dat_q == '0;
      end
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_valid_q <= 1'b0;
      sel_flow_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_valid_i) begin
          if (req_i.action == ActSort) begin
            row_q <= '0; sel_flow_q <= 1'b0; state_q <= S_DIAG;
          end else if (req_i.action == ActBound && row_ok) begin
            loc_q <= RW'(req_i.row_index); fac_q <= '0; state_q <= S_COST;
          end
        end
        S_DIAG: state_q <= S_DIAGR;
        S_DIAGR: begin
          if (9'(row_q) < n - 9'd1) state_q <= S_DIAGW;
          else begin
            row_q <= '0; i_q <= 9'd1;
            if (n > 9'd2) state_q <= S_KEY;
            else begin
              sel_flow_q <= !sel_flow_q; state_q <= sel_flow_q ? S_IDLE : S_DIAG;
            end
          end
        end
        S_DIAGW: begin
          row_q <= row_q + 1'b1; state_q <= S_DIAG;
        end
        S_KEY: begin j_q <= i_q; state_q <= S_CMP; dat_q <= '0; end
        // first visit of an element captures its key
        S_CMP: begin
          if (dat_q == '0) begin key_q <= rd_s; dat_q <= 16'd1; end
          state_q <= S_MOVE;
        end
        S_MOVE: begin
          if (rd_s > key_q && j_q > 9'd1) begin
            j_q <= j_q - 9'd1; state_q <= S_CMP;
          end else begin
            if (rd_s > key_q) j_q <= j_q - 9'd1;
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (i_q + 9'd2 < n) begin
            i_q <= i_q + 9'd1; state_q <= S_KEY;
          end else if (9'(row_q) + 9'd1 < n) begin
            row_q <= row_q + 1'b1; i_q <= 9'd1; state_q <= S_KEY;
          end else if (!sel_flow_q) begin
            sel_flow_q <= 1'b1; row_q <= '0; state_q <= S_DIAG;
          end else begin
            sel_flow_q <= 1'b0; state_q <= S_IDLE;
          end
        end
        S_COST: begin c_q <= '0; state_q <= S_CLD; end
        S_CLD: begin c_q <= 9'd1; state_q <= S_MAC; end
        S_MAC: begin
          if (c_q + 9'd1 < n) c_q <= c_q + 9'd1;
          else state_q <= S_DRAIN;
        end
        S_DRAIN: begin c_q <= '0; dat_q <= '0; state_q <= S_OUT; end
        S_OUT: begin
          if (dat_q == '0 && !res_valid_q) begin
            res_valid_q <= 1'b1; dat_q <= 16'd1;
            res_loc_q <= IdxW'(loc_q); res_fac_q <= IdxW'(fac_q);
            res_bnd_q <= acc; res_last_q <= 9'(fac_q) == n - 9'd1;
            if (9'(fac_q) == n - 9'd1) state_q <= S_IDLE;
            else begin fac_q <= fac_q + 1'b1; state_q <= S_COST; end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_ready_o = state_q == S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o = '{location: res_loc_q, facility: res_fac_q, bound: res_bnd_q,
                   last: res_last_q};

  // checks
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !req_ready_o) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o.bound))
    else $error("result dropped");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> 9'(res_o.facility) == n - 9'd1)
    else $error("bad last");

endmodule

// File: sv/rbm_mac.sv
module rbm_mac
  import rbm_pkg::*;
(
  input  logic            clk_i,
  input  mac_ctl_t        ctl_i,
  input  logic [BndW-1:0] init_i,
  input  logic [EntW-1:0] a_i,
  input  logic [EntW-1:0] b_i,
  output logic [BndW-1:0] acc_o
);

  logic [2*EntW-1:0] prod_q;
  logic [BndW-1:0]   acc_q;

  // registered product, then saturating accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_i.load) begin
      acc_q <= init_i;
    end else if (ctl_i.step) begin
      acc_q <= sat_add(acc_q, prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule
